@@ design/bmsi_pkg.sv @@
// Package for the bank mapper with scanline interrupt counter.
// Holds the item and result types, command codes and register decode constants.
// Used by bmsi_core and bank_mapper_scanline_irq; depends on nothing else.
`timescale 1ns / 1ps

package bmsi_pkg;

    // Command kinds carried in s_tuser.
    localparam logic [1:0] CMD_REG_WRITE  = 2'd0;
    localparam logic [1:0] CMD_SCAN_TICK  = 2'd1;
    localparam logic [1:0] CMD_CPU_LOOKUP = 2'd2;
    localparam logic [1:0] CMD_PPU_LOOKUP = 2'd3;

    // Configuration register indexes.
    localparam int unsigned CFG_IDX_W = 8;
    localparam logic [CFG_IDX_W-1:0] CFG_PRG_BANK_COUNT  = 8'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHR_ROM_PRESENT = 8'd1;
    localparam int unsigned CFG_DATA_W = 9;

    // Register write decode on address bits 15, 14, 13 and 0.
    localparam logic [15:0] ADDR_DECODE_MASK = 16'hE001;
    localparam logic [15:0] ADDR_BANK_SELECT = 16'h8000;
    localparam logic [15:0] ADDR_BANK_DATA   = 16'h8001;
    localparam logic [15:0] ADDR_IRQ_COUNT   = 16'hC000;
    localparam logic [15:0] ADDR_IRQ_RELOAD  = 16'hC001;
    localparam logic [15:0] ADDR_IRQ_DISABLE = 16'hE000;
    localparam logic [15:0] ADDR_IRQ_ENABLE  = 16'hE001;

    localparam logic [7:0] CHR_PAIR_MASK   = 8'hFE;
    localparam logic [8:0] LAST_VIS_LINE   = 9'd239;

    localparam logic [8:0]  PRG_COUNT_RESET = 9'd32;

    typedef struct packed {
        logic [1:0]  command;
        logic [15:0] address;
        logic [7:0]  data;
        logic [8:0]  scanline;
        logic        rendering_on;
    } item_t;

    typedef struct packed {
        logic [7:0] bank;
        logic       mapped;
        logic       screen_page;
        logic       irq_pulse;
    } result_t;

    typedef struct packed {
        logic                  valid;
        logic [CFG_IDX_W-1:0]  index;
        logic [CFG_DATA_W-1:0] data;
    } cfg_wr_t;

endpackage

@@ design/bmsi_core.sv @@
// Mapper state, register write decode, scanline counter and bank lookups.
// Depends on bmsi_pkg; the result is combinational and registered by the top level.
`timescale 1ns / 1ps

module bmsi_core
    import bmsi_pkg::*;
(
    input  logic    clk,
    input  logic    rst_n,
    input  cfg_wr_t cfg,
    input  logic    item_valid,
    input  item_t   item,
    output result_t result
);

    logic [8:0] prg_count_reg;
    logic       chr_present_reg;

    logic [7:0] bank_select_reg, bank_select_next;
    logic [7:0] prg_a_reg, prg_a_next;
    logic [7:0] prg_b_reg, prg_b_next;
    logic [7:0] chr_banks_reg [8];
    logic [7:0] chr_banks_next [8];
    logic       mirror_reg, mirror_next;
    logic [7:0] irq_count_reg, irq_count_next;
    logic [7:0] irq_reload_reg, irq_reload_next;
    logic       irq_on_reg, irq_on_next;

    logic [2:0] slot;
    logic [7:0] even_bank;
    logic [8:0] second_last_w, last_w;
    logic [2:0] ppu_slot;
    logic       pulse;

    assign slot          = bank_select_reg[2:0];
    assign even_bank     = item.data & CHR_PAIR_MASK;
    assign second_last_w = prg_count_reg - 9'd2;
    assign last_w        = prg_count_reg - 9'd1;
    assign ppu_slot      = item.address[12:10] ^ {bank_select_reg[7], 2'b00};

    always_comb
    begin
        bank_select_next = bank_select_reg;
        prg_a_next       = prg_a_reg;
        prg_b_next       = prg_b_reg;
        chr_banks_next   = chr_banks_reg;
        mirror_next      = mirror_reg;
        irq_count_next   = irq_count_reg;
        irq_reload_next  = irq_reload_reg;
        irq_on_next      = irq_on_reg;
        pulse            = 1'b0;
        result.bank      = 8'd0;
        result.mapped    = 1'b0;

        case (item.command)
            CMD_REG_WRITE:
            begin
                case (item.address & ADDR_DECODE_MASK)
                    ADDR_BANK_SELECT: bank_select_next = item.data;
                    ADDR_BANK_DATA:
                    begin
                        if (slot < 3'd6)
                        begin
                            mirror_next = ~item.data[7];
                        end
                        case (slot)
                            3'd0, 3'd1:
                            begin
                                if (chr_present_reg)
                                begin
                                    chr_banks_next[{slot[0], 1'b0, 1'b0} >> 1] = even_bank;
                                    chr_banks_next[({slot[0], 1'b0, 1'b0} >> 1) + 3'd1] =
                                        even_bank + 8'd1;
                                end
                            end
                            3'd2, 3'd3, 3'd4, 3'd5:
                            begin
                                if (chr_present_reg)
                                begin
                                    chr_banks_next[slot + 3'd2] = item.data;
                                end
                            end
                            3'd6:    prg_a_next = item.data;
                            default: prg_b_next = item.data;
                        endcase
                    end
                    ADDR_IRQ_COUNT:   irq_count_next  = item.data;
                    ADDR_IRQ_RELOAD:  irq_reload_next = item.data;
                    ADDR_IRQ_DISABLE: irq_on_next     = 1'b0;
                    ADDR_IRQ_ENABLE:  irq_on_next     = 1'b1;
                    default:          ;
                endcase
            end
            CMD_SCAN_TICK:
            begin
                if (irq_on_reg && (item.scanline <= LAST_VIS_LINE) && item.rendering_on)
                begin
                    if (irq_count_reg == 8'd0)
                    begin
                        irq_count_next = irq_reload_reg;
                        pulse          = 1'b1;
                    end
                    else
                    begin
                        irq_count_next = irq_count_reg - 8'd1;
                    end
                end
            end
            CMD_CPU_LOOKUP:
            begin
                if (item.address[15])
                begin
                    result.mapped = 1'b1;
                    case (item.address[14:13])
                        2'd0:    result.bank = bank_select_reg[6] ? second_last_w[7:0]
                                                                  : prg_a_reg;
                        2'd1:    result.bank = prg_b_reg;
                        2'd2:    result.bank = bank_select_reg[6] ? prg_a_reg
                                                                  : second_last_w[7:0];
                        default: result.bank = last_w[7:0];
                    endcase
                end
            end
            default:
            begin
                if (item.address[15:13] == 3'd0 && chr_present_reg)
                begin
                    result.mapped = 1'b1;
                    result.bank   = chr_banks_reg[ppu_slot];
                end
            end
        endcase

        // The page reported is the one in force after this item.
        result.screen_page = mirror_next;
        result.irq_pulse   = pulse;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg   <= PRG_COUNT_RESET;
            chr_present_reg <= 1'b1;
        end
        else if (cfg.valid)
        begin
            if (cfg.index == CFG_PRG_BANK_COUNT)
            begin
                prg_count_reg <= cfg.data;
            end
            else if (cfg.index == CFG_CHR_ROM_PRESENT)
            begin
                chr_present_reg <= cfg.data[0];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            bank_select_reg <= 8'd0;
            prg_a_reg       <= 8'd0;
            prg_b_reg       <= 8'd1;
            for (int i = 0; i < 8; i++)
            begin
                chr_banks_reg[i] <= 8'(i);
            end
            mirror_reg      <= 1'b0;
            irq_count_reg   <= 8'd0;
            irq_reload_reg  <= 8'd0;
            irq_on_reg      <= 1'b0;
        end
        else if (item_valid)
        begin
            bank_select_reg <= bank_select_next;
            prg_a_reg       <= prg_a_next;
            prg_b_reg       <= prg_b_next;
            chr_banks_reg   <= chr_banks_next;
            mirror_reg      <= mirror_next;
            irq_count_reg   <= irq_count_next;
            irq_reload_reg  <= irq_reload_next;
            irq_on_reg      <= irq_on_next;
        end
    end

endmodule

@@ design/bank_mapper_scanline_irq.sv @@
// Top level of the bank mapper with scanline interrupt counter.
// Instantiates bmsi_core and adds the output register with a skid stage; uses bmsi_pkg.
//
// Throughput: one item per cycle while the skid entry is empty; the whole decode and state
// update fits between the mapper state registers and the output register. rst_n is
// asynchronous and active low; it restores the power-up bank setup, clears the interrupt
// logic and empties the outputs.
`timescale 1ns / 1ps

module bank_mapper_scanline_irq
    import bmsi_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    // Slave side. tdata fields from bit 0: address[15:0], data[7:0], scanline[8:0],
    // rendering_on[0], then zero fill.
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [39:0]           s_tdata,
    // tuser fields from bit 0: command[1:0].
    input  logic [1:0]            s_tuser,
    // Master side. tdata fields from bit 0: bank[7:0], mapped[0], screen_page[0],
    // irq_pulse[0], then zero fill.
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [15:0]           m_tdata,
    // Configuration write channel.
    input  logic                  cfg_valid,
    output logic                  cfg_ready,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_data
);

    item_t   item;
    result_t core_result;
    cfg_wr_t cfg;
    logic    accept;
    logic    pop;

    // Output register and the skid entry that catches an item while the output stalls.
    result_t out_reg;
    logic    out_valid_reg;
    result_t skid_reg;
    logic    skid_valid_reg;

    // Configuration is always taken; the user must write it only while idle; not enforced.
    assign cfg_ready = 1'b1;
    assign cfg.valid = cfg_valid;
    assign cfg.index = cfg_index;
    assign cfg.data  = cfg_data;

    assign item.command      = s_tuser;
    assign item.address      = s_tdata[15:0];
    assign item.data         = s_tdata[23:16];
    assign item.scanline     = s_tdata[32:24];
    assign item.rendering_on = s_tdata[33];

    // Ready depends only on the skid entry, so the slave side never waits on m_tready
    // combinationally; one result may wait in the output register while the next
    // item is accepted.
    assign s_tready = ~skid_valid_reg;
    assign accept   = s_tvalid & s_tready;
    assign pop      = out_valid_reg & m_tready;

    bmsi_core u_core
    (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .item_valid (accept),
        .item       (item),
        .result     (core_result)
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg  <= 1'b0;
            skid_valid_reg <= 1'b0;
        end
        else
        begin
            if (pop)
            begin
                if (skid_valid_reg)
                begin
                    // Skid entry moves up; no item is accepted in this cycle.
                    out_valid_reg  <= 1'b1;
                    skid_valid_reg <= 1'b0;
                end
                else
                begin
                    out_valid_reg <= accept;
                end
            end
            else if (accept)
            begin
                if (!out_valid_reg)
                begin
                    out_valid_reg <= 1'b1;
                end
                else
                begin
                    skid_valid_reg <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && skid_valid_reg)
        begin
            out_reg <= skid_reg;
        end
        else if (accept && (pop || !out_valid_reg))
        begin
            out_reg <= core_result;
        end
        if (accept && out_valid_reg && !pop)
        begin
            skid_reg <= core_result;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = {5'd0, out_reg.irq_pulse, out_reg.screen_page, out_reg.mapped,
                       out_reg.bank};

endmodule
